@@ hdl/dae_pkg.sv @@
`default_nettype none
package dae_pkg;

  // Walker phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_LABEL  = 3'd2,
    PH_PTR    = 3'd3,
    PH_FIXED  = 3'd4,
    PH_RDATA  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  localparam logic [7:0]  PTR_MARK        = 8'hC0;
  localparam logic [15:0] HEADER_LEN      = 16'd12;
  localparam logic [15:0] ANCOUNT_HI_IDX  = 16'd6;
  localparam logic [15:0] ANCOUNT_LO_IDX  = 16'd7;
  localparam logic [15:0] QTAIL_LEN       = 16'd4;
  localparam logic [15:0] RR_FIXED_LEN    = 16'd10;
  localparam logic [15:0] RR_TYPE_HI_IDX  = 16'd0;
  localparam logic [15:0] RR_TYPE_LO_IDX  = 16'd1;
  localparam logic [15:0] RR_LEN_HI_IDX   = 16'd8;
  localparam logic [15:0] RR_LEN_LO_IDX   = 16'd9;
  localparam logic [15:0] ADDR_BYTES      = 16'd4;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [15:0] WANTED_TYPE_RST = 16'd1;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [31:0] address;
    logic        is_end;
    logic        all_parsed;
    logic [15:0] match_count;
  } result_t;

endpackage
`default_nettype wire

@@ hdl/dae_out_fifo.sv @@
`default_nettype none
module dae_out_fifo
  import dae_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  // up to two results per cycle, wr0 first
  input  wire logic [1:0] wr_n,
  input  wire result_t wr0,
  input  wire result_t wr1,
  output logic         room_two,
  output logic         rd_valid,
  input  wire logic    rd_ready,
  output result_t      rd_data
);

  result_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;

  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);
  assign pop       = rd_valid && rd_ready;
  assign rd_valid  = (count_r != '0);
  assign rd_data   = mem[rd_ptr_r];
  // accept a new byte only if both possible results fit
  assign room_two  = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(wr_n);
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (FIFO_AW+1)'(wr_n) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[wr_ptr_p1] <= wr1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dns_a_record_extractor_core.sv @@
`default_nettype none
// Byte-serial DNS response walker: one packet byte per cycle while in_ready is high.
// Each result is registered in the result queue and offered on out_* from its head.
// A byte can cause two results (address, then end); a four-entry result queue
// absorbs them, and in_ready drops only while fewer than two entries are free.
// Reset (rst_n low, synchronous): walker back to header phase, counters zero,
// queue empty, wanted type = 1. Packet state also clears after each end result.
module dns_a_record_extractor_core
  import dae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_pkt_byte,
  input  wire logic        in_pkt_last,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_address,
  output logic             out_is_end,
  output logic             out_all_parsed,
  output logic [15:0]      out_match_count,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_wanted_type
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] field_cnt_r, field_cnt_nxt;
  logic [15:0] ans_total_r, ans_total_nxt;
  logic [15:0] ans_done_r, ans_done_nxt;
  logic [15:0] rec_type_r, rec_type_nxt;
  logic [15:0] data_len_r, data_len_nxt;
  logic [31:0] addr_sh_r, addr_sh_nxt;
  logic [15:0] emit_cnt_r, emit_cnt_nxt;
  logic        in_q_r, in_q_nxt;
  logic [15:0] wanted_r;

  logic        accept;
  logic [15:0] cnt_inc, ans_done_inc, b16;
  logic        addr_hit;
  logic [1:0]  wr_n;
  result_t     wr0, wr1, addr_res, end_res, head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cnt_inc   = field_cnt_r + 16'd1;
  assign ans_done_inc = ans_done_r + 16'd1;
  assign b16       = {8'd0, in_pkt_byte};

  // per-byte walker step
  always_comb begin
    phase_nxt     = phase_r;
    field_cnt_nxt = field_cnt_r;
    ans_total_nxt = ans_total_r;
    ans_done_nxt  = ans_done_r;
    rec_type_nxt  = rec_type_r;
    data_len_nxt  = data_len_r;
    addr_sh_nxt   = addr_sh_r;
    emit_cnt_nxt  = emit_cnt_r;
    in_q_nxt      = in_q_r;
    addr_hit      = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (field_cnt_r == ANCOUNT_HI_IDX) begin
          ans_total_nxt = {in_pkt_byte, 8'd0};
        end else if (field_cnt_r == ANCOUNT_LO_IDX) begin
          ans_total_nxt = ans_total_r | b16;
        end
        field_cnt_nxt = cnt_inc;
        if (cnt_inc == HEADER_LEN) begin
          phase_nxt     = PH_NAME;
          field_cnt_nxt = '0;
          in_q_nxt      = 1'b1;
        end
      end
      PH_NAME: begin
        if (in_pkt_byte == 8'd0) begin
          phase_nxt     = PH_FIXED;
          field_cnt_nxt = '0;
        end else if ((in_pkt_byte & PTR_MARK) == PTR_MARK) begin
          phase_nxt = PH_PTR;
        end else begin
          phase_nxt     = PH_LABEL;
          field_cnt_nxt = b16;
        end
      end
      PH_LABEL: begin
        field_cnt_nxt = field_cnt_r - 16'd1;
        if (field_cnt_r == 16'd1) begin
          phase_nxt = PH_NAME;
        end
      end
      PH_PTR: begin
        phase_nxt     = PH_FIXED;
        field_cnt_nxt = '0;
      end
      PH_FIXED: begin
        if (in_q_r) begin
          // question type and class
          field_cnt_nxt = cnt_inc;
          if (cnt_inc >= QTAIL_LEN) begin
            in_q_nxt      = 1'b0;
            field_cnt_nxt = '0;
            phase_nxt     = (ans_total_r == 16'd0) ? PH_DONE : PH_NAME;
          end
        end else begin
          // answer type, class, ttl, rdlength
          if (field_cnt_r == RR_TYPE_HI_IDX) begin
            rec_type_nxt = {in_pkt_byte, 8'd0};
          end else if (field_cnt_r == RR_TYPE_LO_IDX) begin
            rec_type_nxt = rec_type_r | b16;
          end else if (field_cnt_r == RR_LEN_HI_IDX) begin
            data_len_nxt = {in_pkt_byte, 8'd0};
          end else if (field_cnt_r == RR_LEN_LO_IDX) begin
            data_len_nxt = data_len_r | b16;
          end
          field_cnt_nxt = cnt_inc;
          if (cnt_inc >= RR_FIXED_LEN) begin
            field_cnt_nxt = '0;
            addr_sh_nxt   = '0;
            if (data_len_nxt == 16'd0) begin
              ans_done_nxt = ans_done_inc;
              phase_nxt    = (ans_done_inc == ans_total_r) ? PH_DONE : PH_NAME;
            end else begin
              phase_nxt = PH_RDATA;
            end
          end
        end
      end
      PH_RDATA: begin
        if (field_cnt_r < ADDR_BYTES) begin
          addr_sh_nxt = {addr_sh_r[23:0], in_pkt_byte};
        end
        field_cnt_nxt = cnt_inc;
        if (cnt_inc == ADDR_BYTES && rec_type_r == wanted_r && data_len_r >= ADDR_BYTES) begin
          addr_hit = 1'b1;
          if (emit_cnt_r != COUNT_MAX) begin
            emit_cnt_nxt = emit_cnt_r + 16'd1;
          end
        end
        if (cnt_inc >= data_len_r) begin
          ans_done_nxt  = ans_done_inc;
          phase_nxt     = (ans_done_inc == ans_total_r) ? PH_DONE : PH_NAME;
          field_cnt_nxt = '0;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // results of this byte, address first
  always_comb begin
    addr_res.address     = addr_sh_nxt;
    addr_res.is_end      = 1'b0;
    addr_res.all_parsed  = 1'b0;
    addr_res.match_count = emit_cnt_nxt;
    end_res.address      = '0;
    end_res.is_end       = 1'b1;
    end_res.all_parsed   = (phase_nxt == PH_DONE);
    end_res.match_count  = emit_cnt_nxt;
    wr0  = addr_hit ? addr_res : end_res;
    wr1  = end_res;
    wr_n = 2'd0;
    if (accept) begin
      wr_n = 2'(addr_hit) + 2'(in_pkt_last);
    end
  end

  // walker state; end of packet clears it
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_pkt_last)) begin
      phase_r     <= PH_HEADER;
      field_cnt_r <= '0;
      ans_total_r <= '0;
      ans_done_r  <= '0;
      rec_type_r  <= '0;
      data_len_r  <= '0;
      addr_sh_r   <= '0;
      emit_cnt_r  <= '0;
      in_q_r      <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      field_cnt_r <= field_cnt_nxt;
      ans_total_r <= ans_total_nxt;
      ans_done_r  <= ans_done_nxt;
      rec_type_r  <= rec_type_nxt;
      data_len_r  <= data_len_nxt;
      addr_sh_r   <= addr_sh_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      in_q_r      <= in_q_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= WANTED_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      wanted_r <= cfg_wanted_type;
    end
  end

  dae_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_n     (wr_n),
    .wr0      (wr0),
    .wr1      (wr1),
    .room_two (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign out_address     = head.address;
  assign out_is_end      = head.is_end;
  assign out_all_parsed  = head.all_parsed;
  assign out_match_count = head.match_count;

endmodule
`default_nettype wire
